### hdl/tss_pkg.sv
package tss_pkg;

    // Field widths fixed by the interface
    localparam int OP_W     = 3;
    localparam int HANDLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int KIND_W   = 2;

    // One tick fires at most this many slots
    localparam int MAX_RESULTS = 16;
    localparam int FIRED_W     = $clog2(MAX_RESULTS + 1);

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [HANDLE_W-1:0] t_handle;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [2:0]          t_cls;

    // Operation codes
    localparam t_op OP_TICK      = 3'd0;
    localparam t_op OP_ONE_ABS   = 3'd1;
    localparam t_op OP_ONE_REL   = 3'd2;
    localparam t_op OP_PERIODIC  = 3'd3;
    localparam t_op OP_LIMITED   = 3'd4;
    localparam t_op OP_CANCEL    = 3'd5;

    // Result status codes
    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_FULL       = 3'd1;
    localparam t_status ST_NOT_FOUND  = 3'd2;
    localparam t_status ST_FIRED      = 3'd3;
    localparam t_status ST_NONE_DUE   = 3'd4;
    localparam t_status ST_BAD_HANDLE = 3'd5;

    // Slot kinds
    localparam t_kind KIND_ONE_SHOT = 2'd0;
    localparam t_kind KIND_PERIODIC = 2'd1;
    localparam t_kind KIND_LIMITED  = 2'd2;

    // Decoded class of the current beat
    localparam t_cls CLS_TICK   = 3'd0;
    localparam t_cls CLS_ADD    = 3'd1;
    localparam t_cls CLS_CANCEL = 3'd2;
    localparam t_cls CLS_BAD    = 3'd3;
    localparam t_cls CLS_IGNORE = 3'd4;

    // One slot of the timer table as held in the RAM
    typedef struct packed {
        t_handle handle;
        t_kind   kind;
        t_time   due;
        t_time   period;
        t_time   limit;
        t_time   count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan_clr;
        logic    rd;
        logic    take;
        logic    step;
        logic    set_res;
        t_status res_code;
        logic    push;
        logic    push_last;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_cls cls;
        logic hit;
        logic at_end;
        logic fired_full;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

### hdl/tss_ram.sv
module tss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/tss_ctrl.sv
module tss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tss_pkg::t_sts i_sts,
    output tss_pkg::t_cmd o_cmd
);
    import tss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.cls == CLS_IGNORE) begin
                    n_state = S_IDLE;
                end else if (i_sts.cls == CLS_BAD) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_BAD_HANDLE;
                    n_state      = S_OUT;
                end else begin
                    cmd.scan_clr = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                cmd.rd  = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.hit) begin
                    if (i_sts.cls == CLS_TICK) begin
                        // hold while the previous fired beat cannot leave
                        if (!(i_sts.pend_valid && !i_sts.out_free)) begin
                            cmd.push = i_sts.pend_valid;
                            cmd.take = 1'b1;
                            if (i_sts.fired_full || i_sts.at_end) begin
                                n_state = S_OUT;
                            end else begin
                                cmd.step = 1'b1;
                                n_state  = S_RD;
                            end
                        end
                    end else begin
                        cmd.take = 1'b1;
                        n_state  = S_OUT;
                    end
                end else if (i_sts.at_end) begin
                    if (i_sts.cls == CLS_CANCEL) begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = ST_NOT_FOUND;
                    end else if (i_sts.cls == CLS_ADD) begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = ST_FULL;
                    end
                    n_state = S_OUT;
                end else begin
                    cmd.step = 1'b1;
                    n_state  = S_RD;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

### hdl/tss_dp.sv
module tss_dp #(
    parameter int NUM_SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tss_pkg::t_cmd    i_cmd,
    output tss_pkg::t_sts    o_sts,
    input  tss_pkg::t_op     i_op,
    input  tss_pkg::t_handle i_handle,
    input  tss_pkg::t_time   i_time_value,
    input  tss_pkg::t_time   i_call_limit,
    input  tss_pkg::t_time   i_now,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tss_pkg::t_status o_status,
    output tss_pkg::t_handle o_handle_out,
    output tss_pkg::t_slot   o_slot,
    output logic             o_last
);
    import tss_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Latched beat
    t_cls    r_cls;
    t_op     r_op;
    t_handle r_handle;
    t_time   r_tv;
    t_time   r_limit;
    t_time   r_now;

    // Scan state
    logic [IDX_W-1:0]     r_idx;
    logic [FIRED_W-1:0]   r_fired;
    logic [NUM_SLOTS-1:0] r_used;

    // Result held back until the next one (or the end) is known
    logic    r_pend_valid;
    t_status r_pend_status;
    t_handle r_pend_handle;
    t_slot   r_pend_slot;

    // Output register
    logic    r_o_valid;
    t_status r_o_status;
    t_handle r_o_handle;
    t_slot   r_o_slot;
    logic    r_o_last;

    logic [ENTRY_W-1:0] rd_data;
    t_entry             ent;
    t_entry             wr_ent;
    t_entry             add_ent;
    t_entry             tick_ent;
    logic               used_i;
    logic               hit;
    logic               retire;
    logic               ram_we;
    logic               out_free;
    t_time              cnt1;
    t_cls               cls_in;

    // Decode the incoming beat
    always_comb begin
        unique case (i_op) inside
            OP_TICK: begin
                cls_in = CLS_TICK;
            end
            OP_ONE_ABS, OP_ONE_REL, OP_PERIODIC, OP_LIMITED: begin
                cls_in = (i_handle == '0) ? CLS_BAD : CLS_ADD;
            end
            OP_CANCEL: begin
                cls_in = (i_handle == '0) ? CLS_BAD : CLS_CANCEL;
            end
            default: begin
                cls_in = CLS_IGNORE;
            end
        endcase
    end

    assign ent    = t_entry'(rd_data);
    assign used_i = r_used[r_idx];

    // Slot match for the current class
    always_comb begin
        case (r_cls)
            CLS_TICK:   hit = used_i && !(ent.due > r_now);
            CLS_CANCEL: hit = used_i && (ent.handle == r_handle);
            CLS_ADD:    hit = !used_i;
            default:    hit = 1'b0;
        endcase
    end

    // Fired slot: bump count, reschedule or retire
    assign cnt1 = ent.count + 32'd1;

    always_comb begin
        case (ent.kind)
            KIND_PERIODIC: retire = 1'b0;
            KIND_LIMITED:  retire = (cnt1 >= ent.limit);
            default:       retire = 1'b1;
        endcase
    end

    always_comb begin
        tick_ent       = ent;
        tick_ent.due   = r_now + ent.period;
        tick_ent.count = cnt1;
    end

    // New slot built from the latched beat
    always_comb begin
        add_ent        = '0;
        add_ent.handle = r_handle;
        case (r_op)
            OP_PERIODIC: add_ent.kind = KIND_PERIODIC;
            OP_LIMITED:  add_ent.kind = KIND_LIMITED;
            default:     add_ent.kind = KIND_ONE_SHOT;
        endcase
        add_ent.due = (r_op == OP_ONE_ABS) ? r_tv : (r_now + r_tv);
        if (r_op == OP_PERIODIC || r_op == OP_LIMITED) begin
            add_ent.period = r_tv;
        end
        if (r_op == OP_LIMITED) begin
            add_ent.limit = r_limit;
        end
    end

    assign wr_ent = (r_cls == CLS_ADD) ? add_ent : tick_ent;
    assign ram_we = i_cmd.take &&
                    ((r_cls == CLS_ADD) || (r_cls == CLS_TICK && !retire));

    tss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (wr_ent),
        .i_re    (i_cmd.rd),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    assign out_free = !r_o_valid || i_out_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls        <= CLS_IGNORE;
            r_idx        <= '0;
            r_fired      <= '0;
            r_used       <= '0;
            r_pend_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cls <= cls_in;
            end
            if (i_cmd.scan_clr) begin
                r_idx        <= '0;
                r_fired      <= '0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.set_res || i_cmd.take) begin
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.take) begin
                if (r_cls == CLS_TICK) begin
                    r_fired <= r_fired + 1'b1;
                    if (retire) begin
                        r_used[r_idx] <= 1'b0;
                    end
                end else if (r_cls == CLS_CANCEL) begin
                    r_used[r_idx] <= 1'b0;
                end else begin
                    r_used[r_idx] <= 1'b1;
                end
            end
            if (i_cmd.push) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_op;
            r_handle <= i_handle;
            r_tv     <= i_time_value;
            r_limit  <= i_call_limit;
            r_now    <= i_now;
        end
        if (i_cmd.set_res) begin
            r_pend_status <= i_cmd.res_code;
            r_pend_handle <= (i_cmd.res_code == ST_BAD_HANDLE) ? '0 : r_handle;
            r_pend_slot   <= '0;
        end else if (i_cmd.take) begin
            r_pend_status <= (r_cls == CLS_TICK) ? ST_FIRED : ST_OK;
            r_pend_handle <= (r_cls == CLS_TICK) ? ent.handle : r_handle;
            r_pend_slot   <= t_slot'(r_idx);
        end
        if (i_cmd.push) begin
            r_o_status <= r_pend_valid ? r_pend_status : ST_NONE_DUE;
            r_o_handle <= r_pend_valid ? r_pend_handle : '0;
            r_o_slot   <= r_pend_valid ? r_pend_slot : '0;
            r_o_last   <= i_cmd.push_last;
        end
    end

    assign o_sts.cls        = r_cls;
    assign o_sts.hit        = hit;
    assign o_sts.at_end     = (r_idx == IDX_W'(NUM_SLOTS - 1));
    assign o_sts.fired_full = (r_fired == FIRED_W'(MAX_RESULTS - 1));
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;

    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_handle_out = r_o_handle;
    assign o_slot       = r_o_slot;
    assign o_last       = r_o_last;

endmodule

### hdl/timer_slot_scheduler_core.sv
// Throughput: one beat at a time; each slot visited takes a RAM read, then a check and
// write-back, so a tick visits up to NUM_SLOTS slots and an add or cancel the slots up
// to the hit; an output stall can hold a tick scan or the final result.
// The last result is registered from the output state once the output register is free.
// Reset: synchronous, active low; all slots are free at once (per-slot valid flops).
module timer_slot_scheduler_core #(
    parameter int NUM_SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tss_pkg::t_op     i_op,
    input  tss_pkg::t_handle i_handle,
    input  tss_pkg::t_time   i_time_value,
    input  tss_pkg::t_time   i_call_limit,
    input  tss_pkg::t_time   i_now,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tss_pkg::t_status o_status,
    output tss_pkg::t_handle o_handle_out,
    output tss_pkg::t_slot   o_slot,
    output logic             o_last
);
    import tss_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tss_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_op         (i_op),
        .i_handle     (i_handle),
        .i_time_value (i_time_value),
        .i_call_limit (i_call_limit),
        .i_now        (i_now),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_handle_out (o_handle_out),
        .o_slot       (o_slot),
        .o_last       (o_last)
    );

    // An accepted beat is decoded before another can be taken
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken twice in a row");

    // A fired slot always belongs to a live client
    a_fired_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FIRED) |-> (o_handle_out != '0))
        else $error("fired beat with free slot handle");

    // Nothing-due answer is a lone closing beat
    a_none_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_NONE_DUE) |-> (o_last && o_handle_out == '0))
        else $error("none due beat malformed");

    // Add and cancel answers are single beats
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_OK || o_status == ST_FULL ||
                         o_status == ST_NOT_FOUND || o_status == ST_BAD_HANDLE))
        |-> o_last)
        else $error("add or cancel answer not marked last");

endmodule

### dv/tss_result_checker.sv
module tss_result_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  tss_pkg::t_op     i_op,
    input  tss_pkg::t_handle i_handle,
    input  tss_pkg::t_time   i_time_value,
    input  tss_pkg::t_time   i_call_limit,
    input  tss_pkg::t_time   i_now,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  tss_pkg::t_status i_status,
    input  tss_pkg::t_handle i_handle_out,
    input  tss_pkg::t_slot   i_slot,
    input  logic             i_last,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results_seen
);

    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    typedef struct packed {
        t_status status;
        t_handle handle;
        t_slot   slot;
        logic    last;
    } t_timer_result;

    // Shadow copy of the timer table
    t_handle tbl_handle [NUM_SLOTS];
    t_kind   tbl_kind   [NUM_SLOTS];
    t_time   tbl_due    [NUM_SLOTS];
    t_time   tbl_period [NUM_SLOTS];
    t_time   tbl_limit  [NUM_SLOTS];
    t_time   tbl_count  [NUM_SLOTS];

    // Results still owed by the block, oldest first
    t_timer_result awaited_results[$];

    int fails = 0;
    int results_seen = 0;

    function automatic void clear_slot(int s);
        tbl_handle[s] = '0;
        tbl_kind[s]   = KIND_ONE_SHOT;
        tbl_due[s]    = '0;
        tbl_period[s] = '0;
        tbl_limit[s]  = '0;
        tbl_count[s]  = '0;
    endfunction

    function automatic void owe(t_status st, t_handle h, int s, logic last);
        t_timer_result r;
        r.status = st;
        r.handle = h;
        r.slot   = t_slot'(s);
        r.last   = last;
        awaited_results.push_back(r);
    endfunction

    // Scan the table for a tick: fire due slots, then reschedule or free them
    function automatic void fire_due_slots(t_time now_ms);
        int s;
        int fired;
        fired = 0;
        for (s = 0; s < NUM_SLOTS && fired < MAX_RESULTS; s++) begin
            if (tbl_handle[s] != '0 && !(tbl_due[s] > now_ms)) begin
                owe(ST_FIRED, tbl_handle[s], s, 1'b0);
                fired++;
                tbl_count[s] = tbl_count[s] + 1;
                if (tbl_kind[s] == KIND_PERIODIC) begin
                    tbl_due[s] = now_ms + tbl_period[s];
                end else if (tbl_kind[s] == KIND_LIMITED) begin
                    if (tbl_count[s] >= tbl_limit[s])
                        clear_slot(s);
                    else
                        tbl_due[s] = now_ms + tbl_period[s];
                end else begin
                    clear_slot(s);
                end
            end
        end
        if (fired == 0)
            owe(ST_NONE_DUE, '0, 0, 1'b1);
        else
            awaited_results[awaited_results.size() - 1].last = 1'b1;
    endfunction

    // Work out what one accepted beat does to the table and what it returns
    function automatic void apply_timer_op(t_op op, t_handle h, t_time tv, t_time lim,
                                           t_time now_ms);
        int s;
        int hit;
        hit = -1;
        if (op == OP_TICK) begin
            fire_due_slots(now_ms);
        end else if (op > OP_CANCEL) begin
            // spare codes: nothing happens
        end else if (h == '0) begin
            owe(ST_BAD_HANDLE, '0, 0, 1'b1);
        end else if (op == OP_CANCEL) begin
            for (s = 0; s < NUM_SLOTS && hit < 0; s++)
                if (tbl_handle[s] == h) hit = s;
            if (hit < 0) begin
                owe(ST_NOT_FOUND, h, 0, 1'b1);
            end else begin
                clear_slot(hit);
                owe(ST_OK, h, hit, 1'b1);
            end
        end else begin
            for (s = 0; s < NUM_SLOTS && hit < 0; s++)
                if (tbl_handle[s] == '0) hit = s;
            if (hit < 0) begin
                owe(ST_FULL, h, 0, 1'b1);
            end else begin
                clear_slot(hit);
                tbl_handle[hit] = h;
                case (op)
                    OP_ONE_ABS: tbl_due[hit] = tv;
                    OP_ONE_REL: tbl_due[hit] = now_ms + tv;
                    default: begin
                        tbl_kind[hit]   = (op == OP_PERIODIC) ? KIND_PERIODIC : KIND_LIMITED;
                        tbl_period[hit] = tv;
                        tbl_due[hit]    = now_ms + tv;
                        if (op == OP_LIMITED) tbl_limit[hit] = lim;
                    end
                endcase
                owe(ST_OK, h, hit, 1'b1);
            end
        end
    endfunction

    // Compare output beats, then book expectations for input beats
    always @(posedge i_clk) begin
        t_timer_result want;
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SLOTS; s++) clear_slot(s);
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $error("unexpected result: status %0d handle %0d slot %0d last %0d",
                           i_status, i_handle_out, i_slot, i_last);
                    fails++;
                end else begin
                    want = awaited_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fails++;
                    end
                    if (i_handle_out !== want.handle) begin
                        $error("handle_out: expected %0d, got %0d", want.handle, i_handle_out);
                        fails++;
                    end
                    if (i_slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, i_slot);
                        fails++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_last);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                apply_timer_op(i_op, i_handle, i_time_value, i_call_limit, i_now);
        end
        o_pending      <= awaited_results.size();
        o_fail_count   <= fails;
        o_results_seen <= results_seen;
    end

endmodule

### dv/tb_timer_slot_scheduler_core.sv
module tb_timer_slot_scheduler_core;

    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int RANDOM_BEATS = 340;
    localparam int SETTLE_CYC   = 2 * NUM_SLOTS + 8;
    localparam int HANDLE_POOL  = 24;

    // Spare op codes the block must ignore
    localparam t_op OP_SPARE_6 = 3'd6;
    localparam t_op OP_SPARE_7 = 3'd7;

    logic    i_clk        = 1'b0;
    logic    i_rst_n      = 1'b0;
    logic    i_in_valid   = 1'b0;
    logic    o_in_ready;
    t_op     i_op         = OP_TICK;
    t_handle i_handle     = '0;
    t_time   i_time_value = '0;
    t_time   i_call_limit = '0;
    t_time   i_now        = '0;
    logic    o_out_valid;
    logic    i_out_ready  = 1'b0;
    t_status o_status;
    t_handle o_handle_out;
    t_slot   o_slot;
    logic    o_last;

    int fail_count;
    int pending;
    int results_seen;

    int send_idle = 16;
    int recv_idle = 62;
    int beats_sent = 0;
    int directed_beats = 0;
    t_time wall_ms = '0;

    always #1 i_clk = ~i_clk;

    timer_slot_scheduler_core #(
        .NUM_SLOTS (NUM_SLOTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_handle     (i_handle),
        .i_time_value (i_time_value),
        .i_call_limit (i_call_limit),
        .i_now        (i_now),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_handle_out (o_handle_out),
        .o_slot       (o_slot),
        .o_last       (o_last)
    );

    tss_result_checker #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_handle       (i_handle),
        .i_time_value   (i_time_value),
        .i_call_limit   (i_call_limit),
        .i_now          (i_now),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_status       (o_status),
        .i_handle_out   (o_handle_out),
        .i_slot         (o_slot),
        .i_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // One input beat; valid stays up until the handshake completes
    task automatic send_beat(input t_op op, input t_handle h, input t_time tv,
                             input t_time lim, input t_time now_ms);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_handle     <= h;
        i_time_value <= tv;
        i_call_limit <= lim;
        i_now        <= now_ms;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Hold the sender off until every owed result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic t_time short_or_wild(int span);
        if ($urandom_range(0, 7) == 0) return t_time'($urandom);
        return t_time'($urandom_range(0, span));
    endfunction

    // One random beat; returns 0 for spare ops that the block ignores
    task automatic random_beat(output bit counted);
        int pick;
        t_op op;
        t_handle h;
        pick = $urandom_range(0, 99);
        h = t_handle'($urandom_range(1, HANDLE_POOL));
        counted = 1'b1;
        if (pick < 35) begin
            if (pick < 2) wall_ms = t_time'($urandom);
            else wall_ms = wall_ms + t_time'($urandom_range(0, 12));
            send_beat(OP_TICK, t_handle'($urandom), t_time'($urandom), t_time'($urandom),
                      wall_ms);
        end else if (pick < 75) begin
            op = t_op'($urandom_range(OP_ONE_ABS, OP_LIMITED));
            if (op == OP_ONE_ABS)
                send_beat(op, h, wall_ms + short_or_wild(30), t_time'($urandom), wall_ms);
            else
                send_beat(op, h, short_or_wild(30), short_or_wild(4), wall_ms);
        end else if (pick < 90) begin
            send_beat(OP_CANCEL, h, t_time'($urandom), t_time'($urandom), wall_ms);
        end else if (pick < 94) begin
            send_beat(t_op'($urandom_range(OP_ONE_ABS, OP_CANCEL)), '0, t_time'($urandom),
                      t_time'($urandom), t_time'($urandom));
        end else if (pick < 97) begin
            send_beat(($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7,
                      t_handle'($urandom), t_time'($urandom), t_time'($urandom),
                      t_time'($urandom));
            counted = 1'b0;
        end else begin
            send_beat(t_op'($urandom_range(OP_TICK, OP_CANCEL)), t_handle'($urandom),
                      t_time'($urandom), t_time'($urandom), t_time'($urandom));
        end
    endtask

    // Directed opening, then three random phases with different idling
    initial begin
        t_time tv_set  [4];
        t_time lim_set [4];
        t_handle h;
        int done;
        bit counted;

        tv_set  = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h20};
        lim_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd3};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, handle zero, unknown handle, spare ops
        send_beat(OP_TICK, '0, '0, '0, '0);
        send_beat(OP_ONE_ABS, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(OP_CANCEL, '0, '0, '0, '0);
        send_beat(OP_CANCEL, 16'hFFFF, '0, '0, '0);
        send_beat(OP_SPARE_6, 16'h1234, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0F0F_0F0F);
        send_beat(OP_SPARE_7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // fill every slot with each kind, wrapping relative times and limit zero
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (s == 0) h = 16'hFFFF;
            else if (s == 3 || s == 7) h = 16'h00AA;
            else h = t_handle'(s);
            send_beat(t_op'(OP_ONE_ABS + s % 4), h, tv_set[s / 4], lim_set[s / 4],
                      (s < 8) ? 32'hFFFF_FFF0 : 32'd0);
        end
        send_beat(OP_PERIODIC, 16'h0042, 32'd5, 32'd0, '0);

        // every slot due at the top of the time range
        send_beat(OP_TICK, '0, '0, '0, 32'hFFFF_FFFF);
        send_beat(OP_CANCEL, 16'h00AA, '0, '0, '0);
        send_beat(OP_TICK, '0, '0, '0, 32'd0);
        directed_beats = beats_sent;
        drain_results();

        done = 0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle = 16; recv_idle = 62; end
                1: begin send_idle = 62; recv_idle = 16; wall_ms = 32'hFFFF_FF00; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            while (done < (RANDOM_BEATS * (phase + 1)) / 3) begin
                random_beat(counted);
                if (counted) done++;
                if (done % 50 == 0 && counted) drain_results();
            end
            drain_results();
        end

        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("Sent %0d beats (%0d directed), checked %0d results.",
                 beats_sent, directed_beats, results_seen);
        $display("Idle profiles: sender-light, receiver-light and none; time wrap covered.");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #800_000;
        $display("Timed out with %0d results outstanding", pending);
        $display("Mismatches found");
        $finish;
    end

endmodule
